// ===== rtl/core/decimal_list_parser_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the decimal list parser unit
// Concurrent clocked property checks; compiled out when ASSERT_OFF is set.
// ---------------------------------------------------------------------------
`ifndef DECIMAL_LIST_PARSER_UNIT_MACROS_SVH
`define DECIMAL_LIST_PARSER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clock edge outside reset.
`define DLP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define DLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define DLP_ASSERT(lbl, clk, rst_n, prop, msg)
`define DLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/core/dlp_pkg.sv =====
// ---------------------------------------------------------------------------
// Decimal list parser package
// Shared character codes, request and result types, configuration bundle.
// ---------------------------------------------------------------------------
package dlp_pkg;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam int unsigned VAL_W = 24;
	localparam int unsigned CNT_W = 12;
	localparam int unsigned MAG_W = 25;
	localparam logic [MAG_W-1:0] MAG_CAP = 25'h100_0000;

	localparam int unsigned RES_DEPTH = 4;
	localparam int unsigned RES_AW    = 2;
	localparam int unsigned RES_CW    = 3;

	localparam logic [1:0] REG_MIN_VALUE = 2'd0;
	localparam logic [1:0] REG_MAX_VALUE = 2'd1;
	localparam logic [1:0] REG_MAX_COUNT = 2'd2;

	typedef enum logic [1:0] {
		KIND_VALUE = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef struct packed {
		logic       is_end;
		logic       is_digit;
		logic [3:0] digit;
		logic       is_blank;
		logic       is_ws;
		logic       is_plus;
		logic       is_minus;
		logic       is_comma;
	} item_t;

	typedef struct packed {
		kind_t                    kind;
		logic signed [VAL_W-1:0]  value;
		logic [CNT_W-1:0]         count;
		logic                     last;
	} res_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] min_value;
		logic signed [VAL_W-1:0] max_value;
		logic [CNT_W-1:0]        max_count;
	} cfg_t;

endpackage

// ===== rtl/core/dlp_fifo.sv =====
// ---------------------------------------------------------------------------
// Decimal list parser request queue
// Small register FIFO with occupancy count; head data read directly.
// ---------------------------------------------------------------------------
module dlp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    rp_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			end
			if (do_pop) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wdata;
		end
	end

endmodule

// ===== rtl/core/dlp_front.sv =====
// ---------------------------------------------------------------------------
// Decimal list parser front end
// Classifies each character request and queues it for the parse engine.
// ---------------------------------------------------------------------------
module dlp_front
	import dlp_pkg::*;
#(
	parameter int ITEM_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] ch,
	input  logic       is_end,
	input  logic       push,
	output logic       full,
	output item_t      item,
	output logic       item_valid,
	input  logic       item_take
);

	item_t      cls;
	logic [$bits(item_t)-1:0] rd_bits;
	logic       q_empty;

	always_comb begin
		cls.is_end   = is_end;
		cls.is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
		cls.digit    = ch[3:0];
		cls.is_blank = (ch == CH_SPACE) || (ch == CH_TAB);
		cls.is_ws    = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
		cls.is_plus  = (ch == CH_PLUS);
		cls.is_minus = (ch == CH_MINUS);
		cls.is_comma = (ch == CH_COMMA);
	end

	dlp_fifo #(
		.WIDTH ($bits(item_t)),
		.DEPTH (ITEM_DEPTH)
	) u_item_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cls),
		.full   (full),
		.pop    (item_take),
		.rdata  (rd_bits),
		.empty  (q_empty)
	);

	assign item       = item_t'(rd_bits);
	assign item_valid = !q_empty;

endmodule

// ===== rtl/core/dlp_back.sv =====
// ---------------------------------------------------------------------------
// Decimal list parser engine
// Runs the list grammar on classified requests and queues up to two results per request.
// ---------------------------------------------------------------------------
`include "decimal_list_parser_unit_macros.svh"

module dlp_back
	import dlp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  item_t item,
	input  logic  item_valid,
	output logic  item_take,
	output res_t  res,
	output logic  res_empty,
	input  logic  res_pop
);

	typedef enum logic [2:0] {
		PH_START  = 3'd0,
		PH_WS     = 3'd1,
		PH_SIGN   = 3'd2,
		PH_DIGITS = 3'd3,
		PH_AFTER  = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		H_RUN  = 2'd0,
		H_STOP = 2'd1,
		H_ERR  = 2'd2
	} halt_t;

	phase_t             ph_q, ph_d, bg_ph;
	halt_t              halt_q, halt_d;
	logic               neg_q, neg_d;
	logic [MAG_W-1:0]   mag_q, mag_d, mag_acc, bg_mag;
	logic [CNT_W-1:0]   vcnt_q, vcnt_d, vcnt_inc;
	logic               bg_err;

	logic [28:0]        prod;
	logic signed [25:0] sv;
	logic signed [25:0] lo_ext, hi_ext;
	logic               in_range;

	res_t               r0, r1, r_val, r_fin;
	logic [1:0]         n_res;
	logic               fin_emit, err_now;

	res_t               mem_q [RES_DEPTH];
	logic [RES_AW-1:0]  wp_q, rp_q;
	logic [RES_CW-1:0]  rcnt_q;
	logic               room;
	logic               do_pop;

	assign room      = (rcnt_q <= RES_CW'(RES_DEPTH - 2));
	assign item_take = item_valid && room;
	assign res_empty = (rcnt_q == '0);
	assign do_pop    = res_pop && !res_empty;
	assign res       = mem_q[rp_q];

	// times ten plus digit, saturating
	assign prod    = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1) + {25'b0, item.digit};
	assign mag_acc = (prod > {4'b0, MAG_CAP}) ? MAG_CAP : prod[MAG_W-1:0];

	assign sv       = neg_q ? (26'sd0 - $signed({1'b0, mag_q})) : $signed({1'b0, mag_q});
	assign lo_ext   = {{2{cfg.min_value[VAL_W-1]}}, cfg.min_value};
	assign hi_ext   = {{2{cfg.max_value[VAL_W-1]}}, cfg.max_value};
	assign in_range = (sv >= lo_ext) && (sv <= hi_ext);
	assign vcnt_inc = vcnt_q + CNT_W'(1);

	always_comb begin
		bg_mag = item.is_digit ? {21'b0, item.digit} : '0;
		bg_err = 1'b0;
		bg_ph  = ph_q;
		if (item.is_ws) begin
			bg_ph = PH_WS;
		end else if (item.is_plus || item.is_minus) begin
			bg_ph = PH_SIGN;
		end else if (item.is_digit) begin
			bg_ph = PH_DIGITS;
		end else begin
			bg_err = 1'b1;
		end
	end

	always_comb begin
		r_val.kind  = KIND_VALUE;
		r_val.value = sv[VAL_W-1:0];
		r_val.count = vcnt_q;
		r_val.last  = 1'b0;

		fin_emit = (halt_q == H_RUN) && (ph_q == PH_DIGITS) && in_range;
		err_now  = (halt_q == H_ERR) || ((halt_q == H_RUN) &&
			(((ph_q == PH_DIGITS) && !in_range) || (ph_q == PH_WS) || (ph_q == PH_SIGN)));

		r_fin.kind  = err_now ? KIND_ERROR : KIND_DONE;
		r_fin.value = '0;
		r_fin.count = err_now ? '0 : (fin_emit ? vcnt_inc : vcnt_q);
		r_fin.last  = 1'b1;

		ph_d   = ph_q;
		halt_d = halt_q;
		neg_d  = neg_q;
		mag_d  = mag_q;
		vcnt_d = vcnt_q;
		r0     = r_val;
		r1     = r_fin;
		n_res  = 2'd0;

		if (item.is_end) begin
			r0     = fin_emit ? r_val : r_fin;
			n_res  = fin_emit ? 2'd2 : 2'd1;
			ph_d   = PH_START;
			halt_d = H_RUN;
			neg_d  = 1'b0;
			mag_d  = '0;
			vcnt_d = '0;
		end else if (halt_q == H_RUN) begin
			case (ph_q)
				PH_WS: begin
					if (!item.is_ws) begin
						neg_d = item.is_minus;
						mag_d = bg_mag;
						ph_d  = bg_ph;
						if (bg_err) halt_d = H_ERR;
					end
				end
				PH_SIGN: begin
					if (item.is_digit) begin
						mag_d = bg_mag;
						ph_d  = PH_DIGITS;
					end else begin
						halt_d = H_ERR;
					end
				end
				PH_DIGITS: begin
					if (item.is_digit) begin
						mag_d = mag_acc;
					end else if (!in_range) begin
						halt_d = H_ERR;
					end else begin
						n_res  = 2'd1;
						vcnt_d = vcnt_inc;
						ph_d   = PH_AFTER;
						if (item.is_comma) begin
							ph_d = PH_START;
						end else if (!item.is_blank) begin
							halt_d = H_ERR;
						end
					end
				end
				PH_AFTER: begin
					if (item.is_comma) begin
						ph_d = PH_START;
					end else if (!item.is_blank) begin
						halt_d = H_ERR;
					end
				end
				default: begin
					if (!item.is_blank) begin
						if (vcnt_q >= cfg.max_count) begin
							halt_d = H_STOP;
						end else begin
							neg_d = item.is_minus;
							mag_d = bg_mag;
							ph_d  = bg_ph;
							if (bg_err) halt_d = H_ERR;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_START;
			halt_q <= H_RUN;
			neg_q  <= 1'b0;
			mag_q  <= '0;
			vcnt_q <= '0;
			wp_q   <= '0;
			rp_q   <= '0;
			rcnt_q <= '0;
		end else begin
			if (item_take) begin
				ph_q   <= ph_d;
				halt_q <= halt_d;
				neg_q  <= neg_d;
				mag_q  <= mag_d;
				vcnt_q <= vcnt_d;
				wp_q   <= wp_q + RES_AW'(n_res);
			end
			if (do_pop) begin
				rp_q <= rp_q + RES_AW'(1);
			end
			rcnt_q <= rcnt_q + (item_take ? RES_CW'(n_res) : '0) - (do_pop ? RES_CW'(1) : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (item_take && (n_res != 2'd0)) begin
			mem_q[wp_q] <= r0;
		end
		if (item_take && (n_res == 2'd2)) begin
			mem_q[wp_q + RES_AW'(1)] <= r1;
		end
	end

	`DLP_ASSERT(a_resq_bound, clk, arst_n, rcnt_q <= RES_CW'(RES_DEPTH), "result queue overflow")
	`DLP_ASSERT_NEXT(a_end_clears, clk, arst_n, item_take && item.is_end, (ph_q == PH_START) && (halt_q == H_RUN) && (vcnt_q == '0), "terminator did not clear parse state")
	`DLP_ASSERT_NEXT(a_halt_quiet, clk, arst_n, item_take && !item.is_end && (halt_q != H_RUN), $stable(vcnt_q) && $stable(halt_q) && (rcnt_q <= $past(rcnt_q)), "halted parser changed state or queued a result")
	`DLP_ASSERT_NEXT(a_count_step, clk, arst_n, item_take && !item.is_end, (vcnt_q == $past(vcnt_q)) || (vcnt_q == $past(vcnt_q) + CNT_W'(1)), "value count jumped")

endmodule

// ===== rtl/core/decimal_list_parser_unit.sv =====
// The results of an accepted request are written into the result queue, whose head drives the result ports.
// Throughput: one request per cycle; the engine pauses only while the result
// queue has fewer than two free entries, so it follows the result consumer.
// A request produces zero, one or two results (value, then final status).
// Reset (arst_n low, asynchronous) empties both queues, clears the parse state
// and loads the bounds with the full 24-bit range and the count limit with 4095.
// ---------------------------------------------------------------------------
// Decimal list parser unit
// Parses comma-separated signed decimal lists with range and count limits.
// ---------------------------------------------------------------------------
module decimal_list_parser_unit
	import dlp_pkg::*;
#(
	parameter int ITEM_DEPTH = 2
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [7:0]              ch,
	input  logic                    is_end,
	output logic                    empty,
	input  logic                    pop,
	output logic [1:0]              kind,
	output logic signed [VAL_W-1:0] value,
	output logic [CNT_W-1:0]        count,
	output logic                    last_of_run,
	input  logic                    wr_en,
	input  logic [1:0]              wr_idx,
	input  logic [VAL_W-1:0]        wr_data
);

	cfg_t  cfg_q;
	item_t item;
	logic  item_valid;
	logic  item_take;
	res_t  res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_value <= 24'sh800000;
			cfg_q.max_value <= 24'sh7FFFFF;
			cfg_q.max_count <= 12'hFFF;
		end else if (wr_en) begin
			case (wr_idx)
				REG_MIN_VALUE: cfg_q.min_value <= wr_data;
				REG_MAX_VALUE: cfg_q.max_value <= wr_data;
				REG_MAX_COUNT: cfg_q.max_count <= wr_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	dlp_front #(
		.ITEM_DEPTH (ITEM_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.ch         (ch),
		.is_end     (is_end),
		.push       (push),
		.full       (full),
		.item       (item),
		.item_valid (item_valid),
		.item_take  (item_take)
	);

	dlp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item       (item),
		.item_valid (item_valid),
		.item_take  (item_take),
		.res        (res),
		.res_empty  (empty),
		.res_pop    (pop)
	);

	assign kind        = res.kind;
	assign value       = res.value;
	assign count       = res.count;
	assign last_of_run = res.last;

endmodule

// ===== verif/testbench.sv =====
// ---------------------------------------------------------------------------
// Decimal list parser unit testbench
// Feeds argument texts one character per request, predicts every value and
// final status in a local parser model, and checks each popped result field
// by field. Covers directed syntax cases, bound and count limits, a long
// output hold-off, and random texts under several idle and stall mixes.
// ---------------------------------------------------------------------------
module testbench;
	import dlp_pkg::*;

	localparam int CLK_HIGH      = 4;
	localparam int CLK_LOW       = 4;
	localparam int RESET_CYCLES  = 7;
	localparam int SETTLE_CYCLES = 10;
	localparam int HOLD_CYCLES   = 300;
	localparam int MAX_GAP       = 64;
	localparam int PHASE_ITEMS   = 95;
	localparam int MAX_PRINTS    = 40;
	localparam int TIMEOUT_UNITS = 6_400_000;

	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_SPACE,
		SCAN_SIGN,
		SCAN_DIGITS,
		SCAN_AFTER
	} scan_t;

	typedef enum logic [1:0] {
		RUN_ACTIVE,
		RUN_STOPPED,
		RUN_FAILED
	} run_t;

	logic                    clk     = 1'b0;
	logic                    arst_n  = 1'b0;
	logic                    push    = 1'b0;
	logic                    full;
	logic [7:0]              ch      = '0;
	logic                    is_end  = 1'b0;
	logic                    empty;
	logic                    pop     = 1'b0;
	logic [1:0]              kind;
	logic signed [VAL_W-1:0] value;
	logic [CNT_W-1:0]        count;
	logic                    last_of_run;
	logic                    wr_en   = 1'b0;
	logic [1:0]              wr_idx  = '0;
	logic [VAL_W-1:0]        wr_data = '0;

	logic signed [VAL_W-1:0] cfg_min   = 24'h800000;
	logic signed [VAL_W-1:0] cfg_max   = 24'h7FFFFF;
	logic [CNT_W-1:0]        cfg_count = 12'hFFF;

	scan_t            scan_state = SCAN_IDLE;
	logic             num_neg    = 1'b0;
	logic [MAG_W-1:0] num_mag    = '0;
	logic [CNT_W-1:0] took       = '0;
	run_t             run_state  = RUN_ACTIVE;

	res_t pending_results[$];

	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	int   items_sent     = 0;
	int   error_count    = 0;
	logic hold_active    = 1'b0;
	event hold_start;

	decimal_list_parser_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.ch          (ch),
		.is_end      (is_end),
		.empty       (empty),
		.pop         (pop),
		.kind        (kind),
		.value       (value),
		.count       (count),
		.last_of_run (last_of_run),
		.wr_en       (wr_en),
		.wr_idx      (wr_idx),
		.wr_data     (wr_data)
	);

	always begin
		#CLK_LOW clk = 1'b1;
		#CLK_HIGH clk = 1'b0;
	end

	initial begin
		#TIMEOUT_UNITS;
		$display("testbench: errors");
		$finish;
	end

	function automatic bit is_blank(logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB;
	endfunction

	function automatic bit is_space(logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic void push_result(kind_t k, logic signed [VAL_W-1:0] v,
			logic [CNT_W-1:0] n, logic l);
		res_t r;
		r.kind  = k;
		r.value = v;
		r.count = n;
		r.last  = l;
		pending_results.push_back(r);
	endfunction

	function automatic bit take_number();
		longint v;
		v = num_neg ? -longint'(num_mag) : longint'(num_mag);
		if (v < longint'(cfg_min) || v > longint'(cfg_max)) begin
			run_state = RUN_FAILED;
			return 1'b0;
		end
		push_result(KIND_VALUE, v[VAL_W-1:0], took, 1'b0);
		took       = took + 1'b1;
		scan_state = SCAN_AFTER;
		return 1'b1;
	endfunction

	function automatic void start_number(logic [7:0] c);
		num_neg = 1'b0;
		num_mag = '0;
		if (is_space(c)) begin
			scan_state = SCAN_SPACE;
		end else if (c == CH_PLUS || c == CH_MINUS) begin
			num_neg    = (c == CH_MINUS);
			scan_state = SCAN_SIGN;
		end else if (is_digit(c)) begin
			num_mag    = MAG_W'(c - CH_ZERO);
			scan_state = SCAN_DIGITS;
		end else begin
			run_state = RUN_FAILED;
		end
	endfunction

	function automatic void close_item(logic [7:0] c);
		if (c == CH_COMMA) scan_state = SCAN_IDLE;
		else if (!is_blank(c)) run_state = RUN_FAILED;
	endfunction

	function automatic void advance_parse(logic [7:0] c, logic e);
		int unsigned m;
		if (e) begin
			if (run_state == RUN_ACTIVE) begin
				if (scan_state == SCAN_DIGITS) void'(take_number());
				else if (scan_state == SCAN_SPACE || scan_state == SCAN_SIGN)
					run_state = RUN_FAILED;
			end
			if (run_state == RUN_FAILED) push_result(KIND_ERROR, '0, '0, 1'b1);
			else push_result(KIND_DONE, '0, took, 1'b1);
			scan_state = SCAN_IDLE;
			num_neg    = 1'b0;
			num_mag    = '0;
			took       = '0;
			run_state  = RUN_ACTIVE;
			return;
		end
		if (run_state != RUN_ACTIVE) return;
		case (scan_state)
			SCAN_SPACE: begin
				if (!is_space(c)) start_number(c);
			end
			SCAN_SIGN: begin
				if (is_digit(c)) begin
					num_mag    = MAG_W'(c - CH_ZERO);
					scan_state = SCAN_DIGITS;
				end else begin
					run_state = RUN_FAILED;
				end
			end
			SCAN_DIGITS: begin
				if (is_digit(c)) begin
					m = num_mag * 10 + (c - CH_ZERO);
					if (m > MAG_CAP) m = MAG_CAP;
					num_mag = m[MAG_W-1:0];
				end else if (take_number()) begin
					close_item(c);
				end
			end
			SCAN_AFTER: begin
				close_item(c);
			end
			default: begin
				if (!is_blank(c)) begin
					if (took >= cfg_count) run_state = RUN_STOPPED;
					else start_number(c);
				end
			end
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		if (error_count < MAX_PRINTS) $display("mismatch: %s", msg);
		error_count++;
	endtask

	task automatic check_result();
		res_t want;
		if (pending_results.size() == 0) begin
			report_mismatch($sformatf("unexpected result kind %0d value %0d count %0d",
				kind, value, count));
			return;
		end
		want = pending_results.pop_front();
		if (kind !== want.kind)
			report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
		if (value !== want.value)
			report_mismatch($sformatf("value %0d, want %0d", value, want.value));
		if (count !== want.count)
			report_mismatch($sformatf("count %0d, want %0d", count, want.count));
		if (last_of_run !== want.last)
			report_mismatch($sformatf("last_of_run %0b, want %0b", last_of_run, want.last));
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) check_result();
			pop <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always begin
		@(hold_start);
		hold_active <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_active <= 1'b0;
	end

	task automatic send_item(logic [7:0] c, logic e);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push   <= 1'b1;
		ch     <= c;
		is_end <= e;
		@(posedge clk);
		while (full) @(posedge clk);
		advance_parse(c, e);
		items_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
	endtask

	task automatic send_end();
		send_item(8'($urandom_range(255)), 1'b1);
	endtask

	// hold off new requests until the unit has drained
	task automatic wait_idle();
		push <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_limits(int lo, int hi, int cnt);
		wait_idle();
		wr_en   <= 1'b1;
		wr_idx  <= REG_MIN_VALUE;
		wr_data <= lo[VAL_W-1:0];
		@(posedge clk);
		cfg_min = lo[VAL_W-1:0];
		wr_idx  <= REG_MAX_VALUE;
		wr_data <= hi[VAL_W-1:0];
		@(posedge clk);
		cfg_max = hi[VAL_W-1:0];
		wr_idx  <= REG_MAX_COUNT;
		wr_data <= cnt[VAL_W-1:0];
		@(posedge clk);
		cfg_count = cnt[CNT_W-1:0];
		wr_en <= 1'b0;
	endtask

	task automatic set_random_limits();
		int lo, hi, cnt;
		case ($urandom_range(3))
			0: begin
				lo = -8388608;
				hi = 8388607;
			end
			1: begin
				lo = -int'($urandom_range(500));
				hi = $urandom_range(500);
			end
			2: begin
				lo = $urandom_range(300);
				hi = $urandom_range(300);
			end
			default: begin
				lo = -8388608;
				hi = $urandom_range(9999);
			end
		endcase
		cnt = ($urandom_range(3) == 0) ? $urandom_range(4) : 4095;
		set_limits(lo, hi, cnt);
	endtask

	task automatic send_random_text();
		logic [7:0] text[$];
		int n_nums, n_dig, spot;
		n_nums = $urandom_range(5);
		for (int i = 0; i < n_nums; i++) begin
			if ($urandom_range(3) == 0)
				text.push_back(($urandom_range(5) == 0) ? CH_SPACE :
					CH_TAB + 8'($urandom_range(4)));
			case ($urandom_range(3))
				0: text.push_back(CH_PLUS);
				1: text.push_back(CH_MINUS);
				default: ;
			endcase
			n_dig = ($urandom_range(9) == 0) ? $urandom_range(9, 6) : $urandom_range(3, 1);
			repeat (n_dig) text.push_back(CH_ZERO + 8'($urandom_range(9)));
			if ($urandom_range(3) == 0) text.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
			if (i < n_nums - 1 || $urandom_range(1) == 0) begin
				text.push_back(CH_COMMA);
				if ($urandom_range(3) == 0)
					text.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
			end
		end
		// corrupt a few texts with a stray byte
		if ($urandom_range(99) < 15) begin
			spot = $urandom_range(text.size());
			if (spot < text.size() && $urandom_range(1) == 1)
				text[spot] = 8'($urandom_range(255));
			else
				text.insert(spot, 8'($urandom_range(255)));
		end
		foreach (text[k]) send_item(text[k], 1'b0);
		send_end();
	endtask

	task automatic test_directed();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_end();
		send_text("\015-8388608,\t");
		send_end();
		send_text("+999999999");
		send_end();
		send_text("1 2");
		send_end();
		send_text("- 5");
		send_end();
		send_text("-");
		send_end();
		send_item(8'h00, 1'b0);
		send_end();
	endtask

	task automatic test_limits();
		set_limits(-100, 100, 3);
		send_text("5,-100,100,7x");
		send_end();
		send_text("101");
		send_end();
		set_limits(0, 0, 0);
		send_text(" 9");
		send_end();
		set_limits(10, -10, 4095);
		send_text("0");
		send_end();
		set_limits(8388607, 8388607, 1);
		send_text("8388607,");
		send_end();
		set_limits(-8388608, -8388608, 4095);
		send_text("-8388608");
		send_end();
		set_limits(-8388608, 8388607, 4095);
	endtask

	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		-> hold_start;
		for (int i = 0; i < 20; i++) begin
			send_item(CH_ZERO + 8'(i % 10), 1'b0);
			send_item(CH_COMMA, 1'b0);
		end
		send_end();
		wait_idle();
	endtask

	task automatic test_random();
		int goal;
		for (int mode = 0; mode < 4; mode++) begin
			case (mode)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 84;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 84;
				end
				default: begin
					send_idle_pct  = 34;
					recv_stall_pct = 34;
				end
			endcase
			set_random_limits();
			goal = items_sent + PHASE_ITEMS;
			while (items_sent < goal) begin
				if ($urandom_range(3) == 0) set_random_limits();
				send_random_text();
			end
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_limits();
		test_backpressure();
		test_random();
		wait_idle();
		if (error_count == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
